// ===== src/way_predicted_lru_cache_defines.svh =====
// Assertion helpers used by the cache RTL.
`ifndef WAY_PREDICTED_LRU_CACHE_DEFINES_SVH
`define WAY_PREDICTED_LRU_CACHE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define WPLC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define WPLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/wplc_pkg.sv =====
package wplc_pkg;

   localparam int WAYS        = 4;
   localparam int WAY_W       = 2;
   localparam int ADDR_W      = 25;
   localparam int TAG_W       = 15;
   localparam int TAG_ENTRY_W = 16;
   localparam int LRU_W       = 16;
   localparam int BYTE_W      = 8;

   // All-ones LRU row for each way, and mask that clears that way's column.
   localparam logic [WAYS-1:0][LRU_W-1:0] ROW_ONES =
      {16'h000F, 16'h00F0, 16'h0F00, 16'hF000};
   localparam logic [WAYS-1:0][LRU_W-1:0] COL_KEEP =
      {16'hEEEE, 16'hDDDD, 16'hBBBB, 16'h7777};

   typedef enum logic [1:0] {
      FUNC_LOOKUP = 2'd0,
      FUNC_WRITE  = 2'd1,
      FUNC_ALLOC  = 2'd2
   } func_type;

   // Per-set state: tags with valid in bit 15, LRU matrix, predicted way.
   typedef struct packed {
      logic [WAY_W-1:0]                  pred;
      logic [LRU_W-1:0]                  lru;
      logic [WAYS-1:0][TAG_ENTRY_W-1:0] tags;
   } set_row_type;

   // What one access does to its set and what it reports.
   typedef struct packed {
      logic             row_we;
      set_row_type      row;
      logic             data_we;
      logic [WAY_W-1:0] data_way;
      logic             hit;
      logic [WAY_W-1:0] hit_way;
      logic [WAY_W-1:0] victim_way;
   } set_update_type;

endpackage

// ===== src/wplc_set_logic.sv =====
module wplc_set_logic import wplc_pkg::*; (
   input  logic [1:0]       func,
   input  logic [TAG_W-1:0] tag,
   input  set_row_type      row_cur,
   output set_update_type   upd
);

   logic [TAG_ENTRY_W-1:0] want;
   logic [WAY_W-1:0]       probe_way;
   logic                   found;
   logic [WAY_W-1:0]       found_way;
   logic                   victim_found;
   logic [WAY_W-1:0]       victim;

   assign want = {1'b1, tag};

   // Tag search, starting at the predicted way and wrapping
   always_comb begin
      found     = 1'b0;
      found_way = '0;
      probe_way = row_cur.pred;
      for (int k = 0; k < WAYS; k++) begin
         probe_way = row_cur.pred + WAY_W'(k);
         if (!found && row_cur.tags[probe_way] == want) begin
            found     = 1'b1;
            found_way = probe_way;
         end
      end
   end

   // Victim: lowest way with an empty LRU row, else the last way
   always_comb begin
      victim_found = 1'b0;
      victim       = WAY_W'(WAYS - 1);
      for (int w = 0; w < WAYS - 1; w++) begin
         if (!victim_found && (row_cur.lru & ROW_ONES[w]) == '0) begin
            victim_found = 1'b1;
            victim       = WAY_W'(w);
         end
      end
   end

   // Set update and result per operation
   always_comb begin
      upd          = '0;
      upd.row      = row_cur;
      case (func_type'(func))
         FUNC_LOOKUP: begin
            if (found) begin
               upd.hit     = 1'b1;
               upd.hit_way = found_way;
               upd.row_we  = 1'b1;
               upd.row.lru = (row_cur.lru | ROW_ONES[found_way]) & COL_KEEP[found_way];
            end
         end
         FUNC_WRITE: begin
            upd.data_we  = 1'b1;
            upd.data_way = row_cur.pred;
         end
         FUNC_ALLOC: begin
            upd.row_we           = 1'b1;
            upd.row.tags[victim] = want;
            upd.row.pred         = victim;
            upd.victim_way       = victim;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== src/way_predicted_lru_cache.sv =====
// Requests pass the request stage registers, then the result register.
// Throughput: one access per cycle unless stalled; set-state and line-data
// memories: one read per accepted request, at most one write per completion.
// Back-to-back accesses to one set are forwarded around the memory write.
// Reset (synchronous) clears the per-set valid bits, so tags, LRU and
// prediction read as zero at once; line bytes are not cleared.
module way_predicted_lru_cache import wplc_pkg::*; #(
   parameter int SETS       = 64,
   parameter int LINE_BYTES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_func,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [BYTE_W-1:0] req_write_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_hit,
   output logic [WAY_W-1:0]  rsp_hit_way,
   output logic [BYTE_W-1:0] rsp_read_byte,
   output logic [WAY_W-1:0]  rsp_victim_way
);

`include "way_predicted_lru_cache_defines.svh"

   localparam int OFF_W  = $clog2(LINE_BYTES);
   localparam int SET_W  = $clog2(SETS);
   localparam int DADR_W = SET_W + OFF_W;
   localparam int DEPTH  = SETS * LINE_BYTES;
   localparam int DROW_W = WAYS * BYTE_W;

   // Memories
   set_row_type         set_mem  [SETS];
   logic [DROW_W-1:0]   data_mem [DEPTH];
   logic [SETS-1:0]     set_vld_ff;

   // Request stage
   logic                s1_valid_ff;
   logic [1:0]          s1_func_ff;
   logic [SET_W-1:0]    s1_set_ff;
   logic [DADR_W-1:0]   s1_dadr_ff;
   logic [TAG_W-1:0]    s1_tag_ff;
   logic [BYTE_W-1:0]   s1_byte_ff;
   set_row_type         row_rd_ff;
   logic                row_vld_rd_ff;
   logic                row_fwd_ff;
   set_row_type         row_fwd_data_ff;
   logic [DROW_W-1:0]   data_rd_ff;
   logic [WAYS-1:0]     dfwd_mask_ff;
   logic [BYTE_W-1:0]   dfwd_byte_ff;

   // Result register
   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic [WAY_W-1:0]    rsp_hit_way_ff;
   logic [BYTE_W-1:0]   rsp_read_byte_ff;
   logic [WAY_W-1:0]    rsp_victim_way_ff;

   logic                accept;
   logic                fire_out;
   logic [SET_W-1:0]    req_set;
   logic [DADR_W-1:0]   req_dadr;
   logic [TAG_W-1:0]    req_tag;
   set_row_type         row_cur;
   set_update_type      upd;
   logic [BYTE_W-1:0]   byte_sel;
   logic [BYTE_W-1:0]   read_byte_in;

   // Handshake
   assign fire_out  = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !fire_out;
   assign accept    = req_valid && !req_stall;

   // Address split
   assign req_set  = req_address[OFF_W +: SET_W];
   assign req_dadr = req_address[DADR_W-1:0];
   assign req_tag  = TAG_W'(req_address >> DADR_W);

   // Request stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (fire_out) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff      <= req_func;
         s1_set_ff       <= req_set;
         s1_dadr_ff      <= req_dadr;
         s1_tag_ff       <= req_tag;
         s1_byte_ff      <= req_write_byte;
         row_vld_rd_ff   <= set_vld_ff[req_set];
         row_fwd_ff      <= fire_out && upd.row_we && s1_set_ff == req_set;
         row_fwd_data_ff <= upd.row;
         dfwd_byte_ff    <= s1_byte_ff;
         for (int w = 0; w < WAYS; w++) begin
            dfwd_mask_ff[w] <= fire_out && upd.data_we && s1_dadr_ff == req_dadr &&
                               upd.data_way == WAY_W'(w);
         end
      end
   end

   // Set-state memory: read on request transfer, write on a row update
   always_ff @(posedge clock) begin
      if (accept) begin
         row_rd_ff <= set_mem[req_set];
      end
      if (fire_out && upd.row_we) begin
         set_mem[s1_set_ff] <= upd.row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_vld_ff <= '0;
      end else if (fire_out && upd.row_we) begin
         set_vld_ff[s1_set_ff] <= 1'b1;
      end
   end

   // Line-data memory: one byte lane per way
   always_ff @(posedge clock) begin
      if (accept) begin
         data_rd_ff <= data_mem[req_dadr];
      end
      for (int w = 0; w < WAYS; w++) begin
         if (fire_out && upd.data_we && upd.data_way == WAY_W'(w)) begin
            data_mem[s1_dadr_ff][w*BYTE_W +: BYTE_W] <= s1_byte_ff;
         end
      end
   end

   // Current set state after forwarding
   always_comb begin
      if (row_fwd_ff) begin
         row_cur = row_fwd_data_ff;
      end else if (row_vld_rd_ff) begin
         row_cur = row_rd_ff;
      end else begin
         row_cur = '0;
      end
   end

   wplc_set_logic u_set_logic (
      .func    (s1_func_ff),
      .tag     (s1_tag_ff),
      .row_cur (row_cur),
      .upd     (upd)
   );

   // Byte of the hit way, with forwarding of a just-written byte
   always_comb begin
      byte_sel = data_rd_ff[upd.hit_way*BYTE_W +: BYTE_W];
      if (dfwd_mask_ff[upd.hit_way]) begin
         byte_sel = dfwd_byte_ff;
      end
      read_byte_in = upd.hit ? byte_sel : '0;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire_out) begin
         rsp_hit_ff        <= upd.hit;
         rsp_hit_way_ff    <= upd.hit_way;
         rsp_read_byte_ff  <= read_byte_in;
         rsp_victim_way_ff <= upd.victim_way;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_hit_way    = rsp_hit_way_ff;
   assign rsp_read_byte  = rsp_read_byte_ff;
   assign rsp_victim_way = rsp_victim_way_ff;

   // Checks
   `WPLC_ASSERT_NEXT(a_row_marked_valid, clock, reset, fire_out && upd.row_we,
      set_vld_ff[$past(s1_set_ff)], "written set row not marked valid")
   `WPLC_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_hit,
      rsp_hit_way == '0 && rsp_read_byte == '0, "miss result carries data")
   `WPLC_ASSERT_NOW(a_victim_not_hit, clock, reset, rsp_valid && rsp_victim_way != '0,
      !rsp_hit, "allocate result reports a hit")

endmodule
